// ===== hw/rtl/mpq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpq_pkg
// Shared types and constants for the min priority queue: transaction
// payloads, the entry held in each cell and the command broadcast to the row.
// ----------------------------------------------------------------------------
package mpq_pkg;

    localparam int CAPACITY = 64;
    localparam int CNT_W    = 7;
    localparam int SYM_W    = 16;
    localparam int KEY_W    = 16;

    // action codes
    localparam logic ACT_INSERT  = 1'b0;
    localparam logic ACT_EXTRACT = 1'b1;

    // status codes
    localparam logic [1:0] ST_INSERTED  = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_EXTRACTED = 2'd2;
    localparam logic [1:0] ST_EMPTY     = 2'd3;

    typedef struct packed {
        logic             action;
        logic [SYM_W-1:0] symbol_code;
        logic [KEY_W-1:0] key;
    } t_item;

    typedef struct packed {
        logic [1:0]       status;
        logic [SYM_W-1:0] out_symbol;
        logic [KEY_W-1:0] out_key;
        logic [CNT_W-1:0] occupancy;
    } t_result;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic [KEY_W-1:0] key;
    } t_entry;

    // command broadcast to every cell of the row
    typedef struct packed {
        logic             shift_in;
        logic             shift_out;
        logic [SYM_W-1:0] symbol;
        logic [KEY_W-1:0] key;
    } t_cmd;

endpackage
`default_nettype wire

// ===== hw/rtl/mpq_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpq_cell
// One slot of the sorted shift register. Compares its key with the broadcast
// key and either holds, takes its neighbor's entry or takes the new entry.
// ----------------------------------------------------------------------------
module mpq_cell (
    input  wire logic           i_clk,
    input  wire mpq_pkg::t_cmd   i_cmd,
    input  wire logic           i_valid,
    input  wire logic           i_prev_pos,
    input  wire mpq_pkg::t_entry i_prev_entry,
    input  wire mpq_pkg::t_entry i_next_entry,
    output logic                o_pos,
    output mpq_pkg::t_entry      o_entry
);
    import mpq_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    // new entry belongs at or ahead of this slot: slot empty or key strictly greater
    assign o_pos   = !i_valid || (r_entry.key > i_cmd.key);
    assign o_entry = r_entry;

    // select the next content of the slot
    always_comb begin
        n_entry = r_entry;
        if (i_cmd.shift_in) begin
            if (i_prev_pos) begin
                n_entry = i_prev_entry;
            end else if (o_pos) begin
                n_entry.symbol = i_cmd.symbol;
                n_entry.key    = i_cmd.key;
            end
        end else if (i_cmd.shift_out) begin
            n_entry = i_next_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule
`default_nettype wire

// ===== hw/rtl/min_priority_queue_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// min_priority_queue_top
// Stable min priority queue of (symbol, key) entries kept in a systolic row
// of sorted cells; slot 0 always holds the smallest key.
// ----------------------------------------------------------------------------
// Usage:
//   Drive i_item and raise start; the transaction is taken at a clock edge
//   where start is high and busy is low. action 0 inserts, 1 extracts the
//   entry with the smallest key; equal keys leave first in, first out.
//   The command is registered on acceptance, and at the next edge every cell
//   shifts or holds in parallel while the result is registered. o_done is high
//   for exactly one cycle, registered from busy, with o_result valid.
//   busy is high for the one cycle in between, so the block takes no new
//   transaction while one is in flight, whatever the occupancy; start may
//   be raised again in the cycle o_done is shown.
//   Insert into a full queue returns status full and leaves the queue as is;
//   extract from an empty queue returns status empty. Symbol and key of the
//   result are zero except on a successful extract.
//   Reset empties the queue and drops any transaction in flight. The
//   receiver cannot stall: o_done is a plain strobe.
// ----------------------------------------------------------------------------
module min_priority_queue_top (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    input  wire mpq_pkg::t_item    i_item,
    output logic                  busy,
    output logic                  o_done,
    output mpq_pkg::t_result       o_result
);
    import mpq_pkg::*;

    logic             r_pend;
    t_item            r_item;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    logic   is_full;
    logic   is_empty;
    t_cmd   cmd;
    t_entry zero_entry;

    logic   [CAPACITY-1:0] pos;
    logic   [CAPACITY-1:0] valid;
    t_entry [CAPACITY-1:0] entry;

    assign busy       = r_pend;
    assign is_full    = (r_count == CNT_W'(CAPACITY));
    assign is_empty   = (r_count == '0);
    assign zero_entry = '0;

    // decode the held transaction into the row command
    always_comb begin
        cmd.shift_in  = r_pend && (r_item.action == ACT_INSERT) && !is_full;
        cmd.shift_out = r_pend && (r_item.action == ACT_EXTRACT) && !is_empty;
        cmd.symbol    = r_item.symbol_code;
        cmd.key       = r_item.key;
    end

    // advance the entry count
    always_comb begin
        n_count = r_count;
        if (cmd.shift_in) begin
            n_count = r_count + CNT_W'(1);
        end else if (cmd.shift_out) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    // row of cells, each linked to both neighbors
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        assign valid[g] = (CNT_W'(g) < r_count);

        mpq_cell u_cell (
            .i_clk        (i_clk),
            .i_cmd        (cmd),
            .i_valid      (valid[g]),
            .i_prev_pos   ((g == 0) ? 1'b0 : pos[(g == 0) ? 0 : g-1]),
            .i_prev_entry ((g == 0) ? zero_entry : entry[(g == 0) ? 0 : g-1]),
            .i_next_entry ((g == CAPACITY-1) ? entry[g]
                                             : entry[(g == CAPACITY-1) ? g : g+1]),
            .o_pos        (pos[g]),
            .o_entry      (entry[g])
        );
    end

    // hold the accepted transaction and register the result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend  <= 1'b0;
            r_count <= '0;
            o_done  <= 1'b0;
        end else begin
            o_done <= r_pend;
            if (start && !r_pend) begin
                r_pend <= 1'b1;
                r_item <= i_item;
            end else begin
                r_pend <= 1'b0;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_pend) begin
            o_result.occupancy <= n_count;
            if (r_item.action == ACT_INSERT) begin
                o_result.status     <= is_full ? ST_FULL : ST_INSERTED;
                o_result.out_symbol <= '0;
                o_result.out_key    <= '0;
            end else if (is_empty) begin
                o_result.status     <= ST_EMPTY;
                o_result.out_symbol <= '0;
                o_result.out_key    <= '0;
            end else begin
                o_result.status     <= ST_EXTRACTED;
                o_result.out_symbol <= entry[0].symbol;
                o_result.out_key    <= entry[0].key;
            end
        end
    end

    // an accepted transaction is always answered with o_done
    a_accept_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> ##1 o_done)
        else $error("accepted transaction produced no result");

    // a rejected insert only happens at capacity
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (o_result.status == ST_FULL) |-> o_result.occupancy == CNT_W'(CAPACITY))
        else $error("full status with free slots");

    // an empty report only happens with no entries
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (o_result.status == ST_EMPTY) |-> o_result.occupancy == '0)
        else $error("empty status with entries held");

    // the count never exceeds the number of cells
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

endmodule
`default_nettype wire
